// ===== hdl/wavp_pkg.sv =====
// Shared types and constants for the WAV header parser and PCM unpacker.
package wavp_pkg;

  typedef enum logic [4:0] {
    PH_RIFF  = 5'd0,
    PH_RSIZE = 5'd1,
    PH_WAVE  = 5'd2,
    PH_FMT   = 5'd3,
    PH_FSIZE = 5'd4,
    PH_AFMT  = 5'd5,
    PH_CHAN  = 5'd6,
    PH_RATE  = 5'd7,
    PH_BRATE = 5'd8,
    PH_ALIGN = 5'd9,
    PH_BITS  = 5'd10,
    PH_EXT   = 5'd11,
    PH_DATA  = 5'd12,
    PH_DSIZE = 5'd13,
    PH_SAMP  = 5'd14,
    PH_UNSUP = 5'd15,
    PH_DONE  = 5'd16,
    PH_DRAIN = 5'd17
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_TAG         = 4'd1,
    ERR_FORMAT      = 4'd2,
    ERR_CHANNELS    = 4'd3,
    ERR_RATE        = 4'd4,
    ERR_BITS        = 4'd5,
    ERR_BYTE_RATE   = 4'd6,
    ERR_BLOCK       = 4'd7,
    ERR_FMT_SIZE    = 4'd8,
    ERR_ALIGN       = 4'd9,
    ERR_TRUNCATED   = 4'd10,
    ERR_UNSUPPORTED = 4'd11
  } err_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    kind_t              result_kind;
    err_t               error_code;
    logic [31:0]        rate_out;
    logic [1:0]         channels_out;
    logic [4:0]         sample_bits_out;
    logic [31:0]        frame_count_out;
    logic signed [15:0] sample_value;
    logic               last_sample;
  } result_t;

  // Chunk tags, first character in the top byte.
  localparam logic [31:0] TAG_RIFF = "RIFF";
  localparam logic [31:0] TAG_WAVE = "WAVE";
  localparam logic [31:0] TAG_FMT  = "fmt ";
  localparam logic [31:0] TAG_DATA = "data";

  localparam logic [31:0] MAX_RATE_RESET = 32'd48000;
  localparam logic [31:0] FMT_BASE_SIZE  = 32'd16;
  localparam logic [2:0]  ADDR_MAX_RATE  = 3'd0;

endpackage

// ===== hdl/wavp_cfg_regs.sv =====
// APB register holding the highest accepted sample rate.
module wavp_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] max_sample_rate
);
  import wavp_pkg::*;

  logic hit;

  assign hit    = (paddr[2] == ADDR_MAX_RATE[2]);
  assign pready = 1'b1;
  assign prdata = hit ? max_sample_rate : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sample_rate <= MAX_RATE_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      max_sample_rate <= pwdata;
    end
  end

endmodule

// ===== hdl/wavp_in_stage.sv =====
// Input register stage for incoming file bytes.
module wavp_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      file_byte,
  input  logic            end_of_file,
  input  logic            take,
  output logic            item_valid,
  output wavp_pkg::item_t item
);
  import wavp_pkg::*;

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.file_byte   <= file_byte;
      item.end_of_file <= end_of_file;
    end
  end

endmodule

// ===== hdl/wavp_parser.sv =====
// Byte-wise RIFF/WAVE parser: phase register, field assembly, checks and result decode.
module wavp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wavp_pkg::item_t   item,
  input  logic [31:0]       max_sample_rate,
  output logic              has_result,
  output wavp_pkg::result_t result
);
  import wavp_pkg::*;

  phase_t      phase, phase_next, go_phase;
  logic [31:0] byte_index, byte_index_next;
  logic [31:0] fmt_size, fmt_size_next;
  logic [31:0] held_rate, held_rate_next;
  logic [31:0] held_byte_rate, held_byte_rate_next;
  logic [15:0] held_block_align, held_block_align_next;
  logic [15:0] held_channels, held_channels_next;
  logic [15:0] held_bits, held_bits_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic        pcm_ok, pcm_ok_next;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] bi_inc;
  logic [31:0] tag_word;
  logic [7:0]  tag_char;
  logic [15:0] bits_cur;
  logic        ch1, ch2, b8, b16;
  logic [1:0]  sh;
  logic [34:0] want_brate;
  logic [15:0] want_align;
  err_t        chk_code;
  logic [31:0] remain_full, rem_dec, frames;
  logic        mod_ok;
  logic        ext_end;
  logic        ev_valid, ev_last, idx_wrap;
  kind_t       ev_kind;
  err_t        ev_code;

  assign b      = item.file_byte;
  assign eof    = item.end_of_file;
  assign bi_inc = byte_index + 32'd1;

  always_comb begin
    case (phase)
      PH_RIFF: tag_word = TAG_RIFF;
      PH_WAVE: tag_word = TAG_WAVE;
      PH_FMT:  tag_word = TAG_FMT;
      default: tag_word = TAG_DATA;
    endcase
    case (byte_index[1:0])
      2'd0:    tag_char = tag_word[31:24];
      2'd1:    tag_char = tag_word[23:16];
      2'd2:    tag_char = tag_word[15:8];
      default: tag_char = tag_word[7:0];
    endcase
  end

  // Format checks. On the last bits byte the bits field is still being completed.
  always_comb begin
    bits_cur   = (phase == PH_BITS) ? {b, held_bits[15:8]} : held_bits;
    ch1        = (held_channels == 16'd1);
    ch2        = (held_channels == 16'd2);
    b8         = (bits_cur == 16'd8);
    b16        = (bits_cur == 16'd16);
    sh         = (ch2 && b16) ? 2'd2 : ((ch2 || b16) ? 2'd1 : 2'd0);
    want_brate = {3'b000, held_rate} << sh;
    want_align = 16'd1 << sh;
    if (!pcm_ok) begin
      chk_code = ERR_FORMAT;
    end else if (!(ch1 || ch2)) begin
      chk_code = ERR_CHANNELS;
    end else if (held_rate > max_sample_rate) begin
      chk_code = ERR_RATE;
    end else if (!(b8 || b16)) begin
      chk_code = ERR_BITS;
    end else if (want_brate != {3'b000, held_byte_rate}) begin
      chk_code = ERR_BYTE_RATE;
    end else if (want_align != held_block_align) begin
      chk_code = ERR_BLOCK;
    end else begin
      chk_code = ERR_NONE;
    end
  end

  // Block align can only be 1, 2 or 4 once the format checks pass.
  always_comb begin
    remain_full = {b, data_remaining[31:8]};
    rem_dec     = data_remaining - 32'd1;
    ext_end     = (({1'b0, byte_index} + 33'd17) == {1'b0, fmt_size});
    case (held_block_align)
      16'd1: begin
        mod_ok = 1'b1;
        frames = remain_full;
      end
      16'd2: begin
        mod_ok = !remain_full[0];
        frames = {1'b0, remain_full[31:1]};
      end
      16'd4: begin
        mod_ok = (remain_full[1:0] == 2'd0);
        frames = {2'b00, remain_full[31:2]};
      end
      default: begin
        mod_ok = 1'b0;
        frames = 32'd0;
      end
    endcase
  end

  // Decode what this byte causes.
  always_comb begin
    ev_valid = 1'b0;
    ev_kind  = KIND_HEADER;
    ev_code  = ERR_NONE;
    ev_last  = 1'b0;
    go_phase = phase;
    idx_wrap = 1'b0;
    case (phase)
      PH_RIFF, PH_WAVE, PH_FMT, PH_DATA: begin
        if (b != tag_char) begin
          ev_valid = 1'b1;
          ev_kind  = KIND_ERROR;
          ev_code  = ERR_TAG;
        end else if (byte_index[1:0] == 2'd3) begin
          idx_wrap = 1'b1;
          case (phase)
            PH_RIFF: go_phase = PH_RSIZE;
            PH_WAVE: go_phase = PH_FMT;
            PH_FMT:  go_phase = PH_FSIZE;
            default: go_phase = PH_DSIZE;
          endcase
        end
      end
      PH_RSIZE, PH_FSIZE, PH_RATE, PH_BRATE: begin
        if (byte_index[1:0] == 2'd3) begin
          idx_wrap = 1'b1;
          case (phase)
            PH_RSIZE: go_phase = PH_WAVE;
            PH_FSIZE: go_phase = PH_AFMT;
            PH_RATE:  go_phase = PH_BRATE;
            default:  go_phase = PH_ALIGN;
          endcase
        end
      end
      PH_AFMT, PH_CHAN, PH_ALIGN: begin
        if (byte_index[0]) begin
          idx_wrap = 1'b1;
          case (phase)
            PH_AFMT: go_phase = PH_CHAN;
            PH_CHAN: go_phase = PH_RATE;
            default: go_phase = PH_BITS;
          endcase
        end
      end
      PH_BITS: begin
        if (byte_index[0]) begin
          idx_wrap = 1'b1;
          if (fmt_size < FMT_BASE_SIZE) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_ERROR;
            ev_code  = ERR_FMT_SIZE;
          end else if (fmt_size > FMT_BASE_SIZE) begin
            go_phase = PH_EXT;
          end else if (chk_code != ERR_NONE) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_ERROR;
            ev_code  = chk_code;
          end else begin
            go_phase = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        if (ext_end) begin
          idx_wrap = 1'b1;
          if (chk_code != ERR_NONE) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_ERROR;
            ev_code  = chk_code;
          end else begin
            go_phase = PH_DATA;
          end
        end
      end
      PH_DSIZE: begin
        if (byte_index[1:0] == 2'd3) begin
          idx_wrap = 1'b1;
          ev_valid = 1'b1;
          if (!mod_ok) begin
            ev_kind = KIND_ERROR;
            ev_code = ERR_ALIGN;
          end else if (eof && remain_full != 32'd0) begin
            ev_kind = KIND_ERROR;
            ev_code = ERR_TRUNCATED;
          end else if (ch1 && held_bits == 16'd16) begin
            go_phase = (remain_full == 32'd0) ? PH_DONE : PH_SAMP;
          end else begin
            go_phase = PH_UNSUP;
          end
        end
      end
      PH_SAMP: begin
        if (!byte_index[0]) begin
          if (eof) begin
            ev_valid = 1'b1;
            ev_kind  = KIND_ERROR;
            ev_code  = ERR_TRUNCATED;
          end
        end else begin
          idx_wrap = 1'b1;
          ev_valid = 1'b1;
          if (rem_dec == 32'd0) begin
            go_phase = PH_DONE;
            ev_kind  = KIND_SAMPLE;
            ev_last  = 1'b1;
          end else if (eof) begin
            ev_kind = KIND_ERROR;
            ev_code = ERR_TRUNCATED;
          end else begin
            ev_kind = KIND_SAMPLE;
          end
        end
      end
      PH_UNSUP: begin
        ev_valid = 1'b1;
        ev_kind  = KIND_ERROR;
        ev_code  = ERR_UNSUPPORTED;
      end
      default: begin
      end
    endcase
    // A last byte that ends the file early and says nothing else flags truncation.
    if (eof && !ev_valid && phase != PH_DONE && phase != PH_DRAIN) begin
      ev_valid = 1'b1;
      ev_kind  = KIND_ERROR;
      ev_code  = ERR_TRUNCATED;
    end
  end

  // Next state.
  always_comb begin
    phase_next            = phase;
    byte_index_next       = byte_index;
    fmt_size_next         = fmt_size;
    held_rate_next        = held_rate;
    held_byte_rate_next   = held_byte_rate;
    held_block_align_next = held_block_align;
    held_channels_next    = held_channels;
    held_bits_next        = held_bits;
    data_remaining_next   = data_remaining;
    low_byte_hold_next    = low_byte_hold;
    pcm_ok_next           = pcm_ok;
    if (step) begin
      case (phase)
        PH_DONE, PH_DRAIN, PH_UNSUP: byte_index_next = byte_index;
        default:                     byte_index_next = idx_wrap ? 32'd0 : bi_inc;
      endcase
      case (phase)
        PH_FSIZE: fmt_size_next = {b, fmt_size[31:8]};
        PH_AFMT:  pcm_ok_next = byte_index[0] ? (pcm_ok && b == 8'd0) : (b == 8'd1);
        PH_CHAN:  held_channels_next = {b, held_channels[15:8]};
        PH_RATE:  held_rate_next = {b, held_rate[31:8]};
        PH_BRATE: held_byte_rate_next = {b, held_byte_rate[31:8]};
        PH_ALIGN: held_block_align_next = {b, held_block_align[15:8]};
        PH_BITS:  held_bits_next = bits_cur;
        PH_DSIZE: data_remaining_next = remain_full;
        PH_SAMP: begin
          data_remaining_next = rem_dec;
          if (!byte_index[0]) begin
            low_byte_hold_next = b;
          end
        end
        default: begin
        end
      endcase
      if (eof) begin
        phase_next      = PH_RIFF;
        byte_index_next = 32'd0;
      end else if (ev_valid && ev_kind == KIND_ERROR) begin
        phase_next = PH_DRAIN;
      end else begin
        phase_next = go_phase;
      end
    end
  end

  // Result fields.
  always_comb begin
    has_result = step && ev_valid;
    result     = '0;
    result.result_kind = ev_kind;
    result.error_code  = ev_code;
    case (ev_kind)
      KIND_HEADER: begin
        result.rate_out        = held_rate;
        result.channels_out    = held_channels[1:0];
        result.sample_bits_out = held_bits[4:0];
        result.frame_count_out = frames;
      end
      KIND_SAMPLE: begin
        result.sample_value = {b, low_byte_hold};
        result.last_sample  = ev_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_RIFF;
      byte_index <= 32'd0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  // Every field is fully shifted in before it is used, so these need no reset.
  always_ff @(posedge clk) begin
    fmt_size         <= fmt_size_next;
    held_rate        <= held_rate_next;
    held_byte_rate   <= held_byte_rate_next;
    held_block_align <= held_block_align_next;
    held_channels    <= held_channels_next;
    held_bits        <= held_bits_next;
    data_remaining   <= data_remaining_next;
    low_byte_hold    <= low_byte_hold_next;
    pcm_ok           <= pcm_ok_next;
  end

endmodule

// ===== hdl/wavp_out_stage.sv =====
// Result register stage feeding the output channel.
module wavp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              has_result,
  input  wavp_pkg::result_t result,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output wavp_pkg::result_t result_q
);
  import wavp_pkg::*;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      result_q <= result;
    end
  end

endmodule

// ===== hdl/wav_header_parse_and_pcm_unpack_core.sv =====
// Top level of the WAV header parser and mono 16-bit PCM unpacker.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid / in_ready       file_byte, end_of_file
//  output   out        out_valid / out_ready     result_kind .. last_sample
//  config   in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// One byte is taken every cycle unless a waiting result holds the parser; each byte
// updates the phase register and the field registers of its phase in one pass. A
// result follows its byte from the input register into the result register. While
// a result waits with out_ready low the parser holds, the input register takes at
// most one more byte, and in_ready then stays low until the result is accepted.
// Reset is synchronous and returns the parser to the first RIFF tag byte.
module wav_header_parse_and_pcm_unpack_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         file_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         result_kind,
  output logic [3:0]         error_code,
  output logic [31:0]        rate_out,
  output logic [1:0]         channels_out,
  output logic [4:0]         sample_bits_out,
  output logic [31:0]        frame_count_out,
  output logic signed [15:0] sample_value,
  output logic               last_sample,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wavp_pkg::*;

  item_t       item;
  logic        item_valid;
  logic        slot_free;
  logic        step;
  logic        has_result;
  result_t     result;
  result_t     result_q;
  logic [31:0] max_sample_rate;

  assign step = item_valid && slot_free;

  wavp_cfg_regs u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_sample_rate (max_sample_rate)
  );

  wavp_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .take        (slot_free),
    .item_valid  (item_valid),
    .item        (item)
  );

  wavp_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .item            (item),
    .max_sample_rate (max_sample_rate),
    .has_result      (has_result),
    .result          (result)
  );

  wavp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .has_result (has_result),
    .result     (result),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_q   (result_q)
  );

  assign result_kind     = result_q.result_kind;
  assign error_code      = result_q.error_code;
  assign rate_out        = result_q.rate_out;
  assign channels_out    = result_q.channels_out;
  assign sample_bits_out = result_q.sample_bits_out;
  assign frame_count_out = result_q.frame_count_out;
  assign sample_value    = result_q.sample_value;
  assign last_sample     = result_q.last_sample;

endmodule
